// ===== hdl/dllm_pkg.sv =====
// ----------------------------------------------------------------------------
// dllm_pkg
// shared types, codes and defaults of the doubly linked list manager
// ----------------------------------------------------------------------------
package dllm_pkg;

  // fixed field widths of the request and result words
  localparam int NODE_W   = 8;
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  // default size of the node pool
  localparam int DEF_NODES = 256;

  // generation stamp width of the membership store
  localparam int EPOCH_W = 4;

  // request codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_LINKED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_LINKED = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [NODE_W-1:0]   node;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0]   head_node;
    logic [NODE_W-1:0]   tail_node;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // one entry of the membership store
  typedef struct packed {
    logic               linked;
    logic [EPOCH_W-1:0] epoch;
  } flag_word_t;

  // write strobes and outcome of one list update
  typedef struct packed {
    logic                prev_we;
    logic                next_we;
    logic                flag_we;
    logic                flag_set;
    logic                clear;
    logic [STATUS_W-1:0] status;
  } upd_ctl_t;

endpackage

// ===== hdl/dllm_ram.sv =====
// ----------------------------------------------------------------------------
// dllm_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module dllm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/dllm_update.sv =====
// ----------------------------------------------------------------------------
// dllm_update
// list update of one request from the node's stored links and membership
// ----------------------------------------------------------------------------
module dllm_update import dllm_pkg::*; #(
  parameter int NODES = DEF_NODES
) (
  input  logic [ACTION_W-1:0]        action,
  input  logic [NODE_W-1:0]          node,
  input  logic [$clog2(NODES)-1:0]   prev_rd,
  input  logic [$clog2(NODES)-1:0]   next_rd,
  input  flag_word_t                 flag_rd,
  input  logic [EPOCH_W-1:0]         epoch,
  input  logic [$clog2(NODES)-1:0]   head,
  input  logic [$clog2(NODES)-1:0]   tail,
  input  logic [$clog2(NODES+1)-1:0] count,
  output upd_ctl_t                   ctl,
  output logic [$clog2(NODES)-1:0]   prev_addr,
  output logic [$clog2(NODES)-1:0]   prev_data,
  output logic [$clog2(NODES)-1:0]   next_addr,
  output logic [$clog2(NODES)-1:0]   next_data,
  output logic [$clog2(NODES)-1:0]   head_nxt,
  output logic [$clog2(NODES)-1:0]   tail_nxt,
  output logic [$clog2(NODES+1)-1:0] count_nxt
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  logic [IDX_W-1:0] x;
  logic             in_pool;
  logic             member;
  logic             list_empty;
  logic             is_head;
  logic             is_tail;

  assign x          = IDX_W'(node);
  assign in_pool    = (32'(node) < 32'(NODES));
  assign member     = in_pool && flag_rd.linked && (flag_rd.epoch == epoch);
  assign list_empty = (count == '0);
  assign is_head    = (x == head);
  assign is_tail    = (x == tail);

  always_comb begin
    ctl       = '0;
    ctl.status = ST_DONE;
    prev_addr = x;
    prev_data = x;
    next_addr = x;
    next_data = x;
    head_nxt  = head;
    tail_nxt  = tail;
    count_nxt = count;
    case (action)
      ACT_PUSH_FRONT: begin
        if (!in_pool || member) begin
          ctl.status = ST_ALREADY_LINKED;
        end else begin
          // new node points at the old head, old head points back
          ctl.next_we  = 1'b1;
          next_addr    = x;
          next_data    = head;
          ctl.prev_we  = !list_empty;
          prev_addr    = head;
          prev_data    = x;
          if (list_empty) begin
            tail_nxt = x;
          end
          head_nxt     = x;
          ctl.flag_we  = 1'b1;
          ctl.flag_set = 1'b1;
          count_nxt    = count + CNT_W'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (!in_pool || member) begin
          ctl.status = ST_ALREADY_LINKED;
        end else begin
          ctl.prev_we  = 1'b1;
          prev_addr    = x;
          prev_data    = tail;
          ctl.next_we  = !list_empty;
          next_addr    = tail;
          next_data    = x;
          if (list_empty) begin
            head_nxt = x;
          end
          tail_nxt     = x;
          ctl.flag_we  = 1'b1;
          ctl.flag_set = 1'b1;
          count_nxt    = count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!member) begin
          ctl.status = ST_NOT_LINKED;
        end else begin
          if (is_head && is_tail) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else if (is_head) begin
            head_nxt = next_rd;
          end else if (is_tail) begin
            tail_nxt = prev_rd;
          end else begin
            // middle node: neighbours point past it
            ctl.next_we = 1'b1;
            next_addr   = prev_rd;
            next_data   = next_rd;
            ctl.prev_we = 1'b1;
            prev_addr   = next_rd;
            prev_data   = prev_rd;
          end
          ctl.flag_we = 1'b1;
          count_nxt   = count - CNT_W'(1);
        end
      end
      default: begin
        ctl.clear = 1'b1;
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
    endcase
  end

endmodule

// ===== hdl/doubly_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// doubly linked list over a fixed pool of node indices
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) takes one request word: push a
//   node at the front, push one at the back, remove a node, or clear.
//   out channel (out_valid/out_ready/out_data) returns one word per request
//   with head, tail, count, empty flag and status.
//   each request is taken in the idle state with a read pass over the link
//   memories, and its result word is written to the output register in the
//   exec state with the write pass; no new request is taken before then.
//   a new request is taken while the previous result still waits; if that
//   result is not taken, the next update holds until the output register is
//   free, and no further request is taken meanwhile.
//   reset: the membership memory is swept entry by entry with in_ready
//   low. every 2**EPOCH_W-th clear starts the same sweep.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager import dllm_pkg::*; #(
  parameter int NODES = DEF_NODES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);
  localparam int FLAG_W = $bits(flag_word_t);

  // controller states
  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   sweep_r, sweep_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  in_word_t           req_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic               in_fire;
  logic               exec_fire;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   req_idx;

  // memory ports
  logic [IDX_W-1:0]   prev_rd, next_rd;
  logic [FLAG_W-1:0]  flag_rd_bits;
  flag_word_t         flag_rd;
  logic [IDX_W-1:0]   prev_addr, prev_data, next_addr, next_data;
  logic               flag_we;
  logic [IDX_W-1:0]   flag_addr;
  flag_word_t         flag_wr;
  upd_ctl_t           ctl;
  logic               sweeping;
  logic               epoch_wrap;

  // handshake: a request is taken only when idle, the update waits for room
  assign sweeping  = (state_r == S_SWEEP);
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign rd_idx  = IDX_W'(in_data.node);
  assign req_idx = IDX_W'(req_r.node);
  assign flag_rd = flag_word_t'(flag_rd_bits);

  // previous and next link stores, read on request entry, written on update
  dllm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prev_ram (
    .clk     (clk),
    .we      (exec_fire && ctl.prev_we),
    .wr_addr (prev_addr),
    .wr_data (prev_data),
    .re      (in_fire),
    .rd_addr (rd_idx),
    .rd_data (prev_rd)
  );

  dllm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
    .clk     (clk),
    .we      (exec_fire && ctl.next_we),
    .wr_addr (next_addr),
    .wr_data (next_data),
    .re      (in_fire),
    .rd_addr (rd_idx),
    .rd_data (next_rd)
  );

  // membership store: linked bit plus generation stamp, so a clear only
  // bumps the generation; the sweep wipes stale stamps before they recur
  always_comb begin
    if (sweeping) begin
      flag_we   = 1'b1;
      flag_addr = sweep_r;
      flag_wr   = '0;
    end else begin
      flag_we        = exec_fire && ctl.flag_we;
      flag_addr      = req_idx;
      flag_wr.linked = ctl.flag_set;
      flag_wr.epoch  = epoch_r;
    end
  end

  dllm_ram #(.WIDTH(FLAG_W), .DEPTH(NODES)) u_flag_ram (
    .clk     (clk),
    .we      (flag_we),
    .wr_addr (flag_addr),
    .wr_data (FLAG_W'(flag_wr)),
    .re      (in_fire),
    .rd_addr (rd_idx),
    .rd_data (flag_rd_bits)
  );

  // list update from the read data of the held request
  dllm_update #(.NODES(NODES)) u_update (
    .action    (req_r.action),
    .node      (req_r.node),
    .prev_rd   (prev_rd),
    .next_rd   (next_rd),
    .flag_rd   (flag_rd),
    .epoch     (epoch_r),
    .head      (head_r),
    .tail      (tail_r),
    .count     (count_r),
    .ctl       (ctl),
    .prev_addr (prev_addr),
    .prev_data (prev_data),
    .next_addr (next_addr),
    .next_data (next_data),
    .head_nxt  (head_nxt),
    .tail_nxt  (tail_nxt),
    .count_nxt (count_nxt)
  );

  // generation wraps back to a value that stale entries may still carry
  assign epoch_wrap = ctl.clear && (epoch_r == {EPOCH_W{1'b1}});

  // controller
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    epoch_nxt = epoch_r;
    case (state_r)
      S_SWEEP: begin
        sweep_nxt = sweep_r + IDX_W'(1);
        if (sweep_r == IDX_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
          sweep_nxt = '0;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = epoch_wrap ? S_SWEEP : S_IDLE;
          if (ctl.clear) begin
            epoch_nxt = epoch_r + EPOCH_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      epoch_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      epoch_r <= epoch_nxt;
      if (exec_fire) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request hold and result word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    if (exec_fire) begin
      out_data_r.is_empty  <= (count_nxt == '0);
      out_data_r.head_node <= (count_nxt == '0) ? '0 : NODE_W'(head_nxt);
      out_data_r.tail_node <= (count_nxt == '0) ? '0 : NODE_W'(tail_nxt);
      out_data_r.count     <= COUNT_W'(count_nxt);
      out_data_r.status    <= ctl.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/doubly_linked_list_manager_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_tb
// self-checking bench for the doubly linked list manager
// ----------------------------------------------------------------------------
// drives request words (push front, push back, remove, clear) over the in
// channel and keeps its own copy of the list: links, membership, head, tail
// and count. every result word is checked field by field against the view
// of the list that the copy gives after the same request. the sender runs in
// bursts with gaps, the receiver stalls on a pattern of its own. directed
// tests cover the single-node list, removal at head, tail and middle, the
// ignored requests, clears (enough of them to wrap the membership
// generations) and a completely full pool; random traffic then follows.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager_tb;
  import dllm_pkg::*;

  // run length guard: ~1250 words, each at worst a long gap, a long output
  // stall and the block's own read and write passes, plus the reset and clear sweeps
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [COUNT_W-1:0] NO_LINK = COUNT_W'(DEF_NODES);
  localparam int MAX_REPORTS = 40;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  doubly_linked_list_manager DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // shadow copy of the list
  // --------------------------------------------------------------------------
  // links hold a node index, or NO_LINK when there is no neighbour
  logic [COUNT_W-1:0] lst_prev   [DEF_NODES];
  logic [COUNT_W-1:0] lst_next   [DEF_NODES];
  logic               lst_member [DEF_NODES];
  logic [NODE_W-1:0]  lst_head   = '0;
  logic [NODE_W-1:0]  lst_tail   = '0;
  logic [COUNT_W-1:0] lst_count  = '0;

  // list views still owed by the block, oldest first
  out_word_t list_view_q [$];

  // bookkeeping
  int          burst_left      = 0;
  int          words_sent      = 0;
  int          results_checked = 0;
  int          error_count     = 0;
  int          clear_count     = 0;
  int          ignored_count   = 0;
  int          peak_count      = 0;
  int unsigned cycle_count     = 0;

  initial begin
    lst_prev   = '{default: '0};
    lst_next   = '{default: '0};
    lst_member = '{default: 1'b0};
  end

  // applies one request to the shadow list and returns the view the block
  // must report afterwards
  function automatic out_word_t apply_list_request(input in_word_t req);
    out_word_t          res;
    logic [STATUS_W-1:0] st;
    logic [COUNT_W-1:0] p;
    logic [COUNT_W-1:0] n;
    logic [NODE_W-1:0]  x;
    x  = req.node;
    st = ST_DONE;
    case (req.action)
      ACT_PUSH_FRONT: begin
        if (lst_member[x]) begin
          st = ST_ALREADY_LINKED;
        end else begin
          lst_prev[x] = NO_LINK;
          if (lst_count == 0) begin
            lst_next[x] = NO_LINK;
            lst_tail    = x;
          end else begin
            lst_next[x]        = {1'b0, lst_head};
            lst_prev[lst_head] = {1'b0, x};
          end
          lst_head      = x;
          lst_member[x] = 1'b1;
          lst_count++;
        end
      end
      ACT_PUSH_BACK: begin
        if (lst_member[x]) begin
          st = ST_ALREADY_LINKED;
        end else begin
          lst_next[x] = NO_LINK;
          if (lst_count == 0) begin
            lst_prev[x] = NO_LINK;
            lst_head    = x;
          end else begin
            lst_prev[x]        = {1'b0, lst_tail};
            lst_next[lst_tail] = {1'b0, x};
          end
          lst_tail      = x;
          lst_member[x] = 1'b1;
          lst_count++;
        end
      end
      ACT_REMOVE: begin
        if (!lst_member[x]) begin
          st = ST_NOT_LINKED;
        end else begin
          p = lst_prev[x];
          n = lst_next[x];
          if (x == lst_head && x == lst_tail) begin
            lst_head = '0;
            lst_tail = '0;
          end else if (x == lst_head) begin
            if (n != NO_LINK) begin
              lst_prev[n[NODE_W-1:0]] = NO_LINK;
              lst_head                = n[NODE_W-1:0];
            end
          end else if (x == lst_tail) begin
            if (p != NO_LINK) begin
              lst_next[p[NODE_W-1:0]] = NO_LINK;
              lst_tail                = p[NODE_W-1:0];
            end
          end else begin
            if (p != NO_LINK) begin
              lst_next[p[NODE_W-1:0]] = n;
            end
            if (n != NO_LINK) begin
              lst_prev[n[NODE_W-1:0]] = p;
            end
          end
          lst_prev[x]   = NO_LINK;
          lst_next[x]   = NO_LINK;
          lst_member[x] = 1'b0;
          if (lst_count > 0) begin
            lst_count--;
          end
        end
      end
      default: begin
        // clear drops membership only, links stay as they are
        lst_member = '{default: 1'b0};
        lst_head   = '0;
        lst_tail   = '0;
        lst_count  = '0;
        clear_count++;
      end
    endcase

    if (st != ST_DONE) begin
      ignored_count++;
    end
    if (int'(lst_count) > peak_count) begin
      peak_count = int'(lst_count);
    end

    res.head_node = (lst_count == 0) ? '0 : lst_head;
    res.tail_node = (lst_count == 0) ? '0 : lst_tail;
    res.count     = lst_count;
    res.is_empty  = (lst_count == 0);
    res.status    = st;
    return res;
  endfunction

  // random node that is (or is not) in the list; falls back to any node
  function automatic logic [NODE_W-1:0] pick_node(input logic want_linked);
    int start;
    int idx;
    start = $urandom_range(0, DEF_NODES - 1);
    for (int k = 0; k < DEF_NODES; k++) begin
      idx = (start + k) % DEF_NODES;
      if (lst_member[idx] == want_linked) begin
        return idx[NODE_W-1:0];
      end
    end
    return start[NODE_W-1:0];
  endfunction

  function automatic logic [ACTION_W-1:0] random_push_code();
    return ($urandom_range(0, 1) == 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
  endfunction

  // --------------------------------------------------------------------------
  // clock, cycle counter and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d list views still owed", $time, list_view_q.size());
    $display("doubly_linked_list_manager test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: out_ready follows phases of always-ready, coin-flip and
  // mostly-stalled behaviour, each phase of random length
  // --------------------------------------------------------------------------
  initial begin : sink_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checking: each taken result word against the oldest owed view
  // --------------------------------------------------------------------------
  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (list_view_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result word, expected none, actual %h",
                   $time, out_data);
        end
      end else begin
        want = list_view_q.pop_front();
        results_checked++;
        check_field("head_node", int'(want.head_node), int'(out_data.head_node));
        check_field("tail_node", int'(want.tail_node), int'(out_data.tail_node));
        check_field("count",     int'(want.count),     int'(out_data.count));
        check_field("is_empty",  int'(want.is_empty),  int'(out_data.is_empty));
        check_field("status",    int'(want.status),    int'(out_data.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  // valid stays high across a burst; between bursts it drops and the sender
  // waits on the clock before raising it, so it is never lowered and raised in the same step
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] nd);
    in_word_t  w;
    out_word_t view;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    w.action = act;
    w.node   = nd;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: record the list view the block now owes
    view = apply_list_request(w);
    list_view_q.insert(list_view_q.size(), view);
    words_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
    end
  endtask

  // hold the sender until every owed result word has come back
  task automatic wait_drained();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    while (list_view_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // one-node list at both ends of the index range, plus ignored requests
  task automatic test_single_node();
    send_word(ACT_PUSH_FRONT, 8'd0);      // push into empty list
    send_word(ACT_REMOVE,     8'd0);      // remove the only node
    send_word(ACT_REMOVE,     8'd0);      // remove of unlinked node
    send_word(ACT_PUSH_BACK,  8'd255);    // push back into empty list
    send_word(ACT_PUSH_BACK,  8'd255);    // push of linked node, back
    send_word(ACT_PUSH_FRONT, 8'd255);    // push of linked node, front
    send_word(ACT_CLEAR,      8'd255);
  endtask

  // removal at head, tail and middle; clear on empty and membership after it
  task automatic test_remove_positions();
    send_word(ACT_PUSH_BACK,  8'd1);
    send_word(ACT_PUSH_BACK,  8'd2);
    send_word(ACT_PUSH_BACK,  8'd3);
    send_word(ACT_PUSH_BACK,  8'd4);
    send_word(ACT_PUSH_FRONT, 8'd170);
    send_word(ACT_REMOVE,     8'd170);    // head
    send_word(ACT_REMOVE,     8'd4);      // tail
    send_word(ACT_REMOVE,     8'd2);      // middle
    send_word(ACT_REMOVE,     8'd1);      // head, leaves a single node
    send_word(ACT_REMOVE,     8'd3);      // last node
    send_word(ACT_CLEAR,      8'd85);     // clear of an empty list
    send_word(ACT_PUSH_FRONT, 8'd3);
    send_word(ACT_PUSH_BACK,  8'd2);
    send_word(ACT_CLEAR,      8'd0);
    send_word(ACT_REMOVE,     8'd3);      // unlinked again after clear
    send_word(ACT_PUSH_FRONT, 8'd2);      // relinks after clear
  endtask

  // many clears in a row of short lists, enough to wrap the membership
  // generations and trigger the sweep more than once
  task automatic test_clear_generations();
    int n;
    for (int r = 0; r < 40; r++) begin
      n = $urandom_range(0, 3);
      repeat (n) send_word(random_push_code(), pick_node(1'b0));
      if (lst_count != 0 && $urandom_range(0, 1) == 1) begin
        send_word(ACT_REMOVE, pick_node(1'b1));
      end
      send_word(ACT_CLEAR, 8'($urandom));
      // a node linked before the clear must be free now
      if ($urandom_range(0, 3) == 0) begin
        send_word(ACT_REMOVE, 8'($urandom));
      end
    end
  endtask

  // every node linked: count reaches its top value, then a partial teardown
  task automatic test_full_pool();
    send_word(ACT_CLEAR, 8'd0);
    repeat (DEF_NODES) send_word(random_push_code(), pick_node(1'b0));
    send_word(random_push_code(), 8'($urandom));    // nothing left to link
    repeat (DEF_NODES / 2) send_word(ACT_REMOVE, pick_node(1'b1));
    repeat (16) send_word(random_push_code(), pick_node(1'b0));
  endtask

  // mostly well-formed traffic steering the list length towards a moving
  // target, with some ignored requests and the odd clear mixed in
  task automatic random_traffic(input int n_words, input int size_cap);
    int                  target;
    int                  r;
    logic                grow;
    logic [ACTION_W-1:0] act;
    logic [NODE_W-1:0]   nd;
    target = $urandom_range(0, size_cap);
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 63) == 0) begin
        target = $urandom_range(0, size_cap);
      end
      if (i % 250 == 249) begin
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
        act = ACT_CLEAR;
        nd  = 8'($urandom);
      end else if (r < 7) begin
        // push that should bounce off a linked node
        act = random_push_code();
        nd  = (lst_count != 0) ? pick_node(1'b1) : 8'($urandom);
      end else if (r < 12) begin
        // remove of an arbitrary node, usually not linked
        act = ACT_REMOVE;
        nd  = 8'($urandom);
      end else begin
        if (lst_count == 0) begin
          grow = 1'b1;
        end else if (lst_count >= DEF_NODES) begin
          grow = 1'b0;
        end else if ($urandom_range(0, 3) != 0) begin
          grow = (lst_count < target);
        end else begin
          grow = (lst_count >= target);
        end
        if (grow) begin
          act = random_push_code();
          nd  = pick_node(1'b0);
        end else begin
          act = ACT_REMOVE;
          nd  = pick_node(1'b1);
        end
      end
      send_word(act, nd);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    // reset is held low first; the block then sweeps its membership store
    // with in_ready low, which the handshake waits absorb
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_single_node();
    test_remove_positions();
    wait_drained();
    test_clear_generations();
    wait_drained();
    test_full_pool();
    wait_drained();
    random_traffic(300, 8);
    random_traffic(400, DEF_NODES);

    // all owed words back, then an idle stretch to catch strays
    wait_drained();
    repeat (16) @(posedge clk);

    $display("run covered %0d request words and %0d checked results in %0d cycles",
             words_sent, results_checked, cycle_count);
    $display("%0d clears, %0d ignored requests, longest list %0d nodes, %0d errors",
             clear_count, ignored_count, peak_count, error_count);
    if (error_count == 0) begin
      $display("doubly_linked_list_manager test passed");
    end else begin
      $display("doubly_linked_list_manager test failed");
    end
    $finish;
  end

endmodule
